### src/mpam_pkg.sv
// ----------------------------------------------------------------------------
// mpam_pkg
// Shared constants, codes and types of the multi-pattern automaton matcher.
// ----------------------------------------------------------------------------
package mpam_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned ALPHABET_DEF  = 26;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned STATUS_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PAT_LETTER  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAT_END     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEXT_LETTER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TEXT_START  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PHASE = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DECODE, S_INS_CHK, S_TXT_STEP, S_TXT_HIT,
    S_E_RD, S_E_V, S_E_FV, S_A_FAIL, S_A_AF, S_A_ACC, S_NEXT_C,
    S_DEQ, S_D_U, S_D_FU, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_TAKE, OP_RD_INS, OP_INS_UPD, OP_MARK, OP_ERR,
    OP_ERR_TXT, OP_TSTART, OP_RD_SCAN, OP_TXT_STEP, OP_TXT_HIT, OP_B_INIT,
    OP_RD_UC, OP_LATCH_V, OP_LATCH_FV, OP_WR_FAIL, OP_LATCH_AF, OP_WR_ACC,
    OP_NEXT_C, OP_DEQ_RD, OP_LD_U, OP_LD_FU, OP_B_DONE, OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic              built;
    logic [KIND_W-1:0] kind;
    logic              letter_ok;
    logic              edge_zero;  // edge read data is zero
    logic              v_zero;     // latched child is zero
    logic              is_root;
    logic              c_last;
    logic              q_empty;
    logic              clr_last;
    logic              out_free;
  } dp_stat_t;

endpackage

### src/mpam_ram.sv
// ----------------------------------------------------------------------------
// mpam_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mpam_ctrl.sv
// ----------------------------------------------------------------------------
// mpam_ctrl
// Sequencer: decodes items, steps the breadth-first build, loads results.
// ----------------------------------------------------------------------------
module mpam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpam_pkg::dp_stat_t stat,
  output mpam_pkg::dp_cmd_t  cmd
);

  mpam_pkg::state_t state, state_next;

  logic ok_ins, ok_mark, ok_build, ok_txt, bad_txt, ok_tstart;

  always_comb begin
    ok_ins    = stat.kind == mpam_pkg::KIND_PAT_LETTER && !stat.built && stat.letter_ok;
    ok_mark   = stat.kind == mpam_pkg::KIND_PAT_END && !stat.built;
    ok_build  = stat.kind == mpam_pkg::KIND_BUILD && !stat.built;
    ok_txt    = stat.kind == mpam_pkg::KIND_TEXT_LETTER && stat.built && stat.letter_ok;
    bad_txt   = stat.kind == mpam_pkg::KIND_TEXT_LETTER && stat.built && !stat.letter_ok;
    ok_tstart = stat.kind == mpam_pkg::KIND_TEXT_START && stat.built;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpam_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mpam_pkg::S_CLR:      if (stat.clr_last) state_next = mpam_pkg::S_IDLE;
      mpam_pkg::S_IDLE:     if (in_valid) state_next = mpam_pkg::S_DECODE;
      mpam_pkg::S_DECODE: begin
        priority if (ok_ins)   state_next = mpam_pkg::S_INS_CHK;
        else if (ok_build)     state_next = mpam_pkg::S_E_RD;
        else if (ok_txt)       state_next = mpam_pkg::S_TXT_STEP;
        else                   state_next = mpam_pkg::S_FIN;
      end
      mpam_pkg::S_INS_CHK:  state_next = mpam_pkg::S_FIN;
      mpam_pkg::S_TXT_STEP: state_next = mpam_pkg::S_TXT_HIT;
      mpam_pkg::S_TXT_HIT:  state_next = mpam_pkg::S_FIN;
      mpam_pkg::S_E_RD:     state_next = mpam_pkg::S_E_V;
      mpam_pkg::S_E_V: begin
        priority if (!stat.is_root) state_next = mpam_pkg::S_E_FV;
        else if (stat.edge_zero)    state_next = mpam_pkg::S_NEXT_C;
        else                        state_next = mpam_pkg::S_A_FAIL;
      end
      mpam_pkg::S_E_FV:
        state_next = stat.v_zero ? mpam_pkg::S_NEXT_C : mpam_pkg::S_A_FAIL;
      mpam_pkg::S_A_FAIL:   state_next = mpam_pkg::S_A_AF;
      mpam_pkg::S_A_AF:     state_next = mpam_pkg::S_A_ACC;
      mpam_pkg::S_A_ACC:    state_next = mpam_pkg::S_NEXT_C;
      mpam_pkg::S_NEXT_C:
        state_next = stat.c_last ? mpam_pkg::S_DEQ : mpam_pkg::S_E_RD;
      mpam_pkg::S_DEQ:
        state_next = stat.q_empty ? mpam_pkg::S_FIN : mpam_pkg::S_D_U;
      mpam_pkg::S_D_U:      state_next = mpam_pkg::S_D_FU;
      mpam_pkg::S_D_FU:     state_next = mpam_pkg::S_E_RD;
      mpam_pkg::S_FIN:      if (stat.out_free) state_next = mpam_pkg::S_IDLE;
      default:              state_next = mpam_pkg::S_CLR;
    endcase
  end

  always_comb begin
    cmd.op   = mpam_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      mpam_pkg::S_CLR: cmd.op = mpam_pkg::OP_CLR;
      mpam_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = mpam_pkg::OP_TAKE;
      end
      mpam_pkg::S_DECODE: begin
        priority if (ok_ins) cmd.op = mpam_pkg::OP_RD_INS;
        else if (ok_mark)    cmd.op = mpam_pkg::OP_MARK;
        else if (ok_build)   cmd.op = mpam_pkg::OP_B_INIT;
        else if (ok_txt)     cmd.op = mpam_pkg::OP_RD_SCAN;
        else if (bad_txt)    cmd.op = mpam_pkg::OP_ERR_TXT;
        else if (ok_tstart)  cmd.op = mpam_pkg::OP_TSTART;
        else                 cmd.op = mpam_pkg::OP_ERR;
      end
      mpam_pkg::S_INS_CHK:  cmd.op = mpam_pkg::OP_INS_UPD;
      mpam_pkg::S_TXT_STEP: cmd.op = mpam_pkg::OP_TXT_STEP;
      mpam_pkg::S_TXT_HIT:  cmd.op = mpam_pkg::OP_TXT_HIT;
      mpam_pkg::S_E_RD:     cmd.op = mpam_pkg::OP_RD_UC;
      mpam_pkg::S_E_V:      cmd.op = mpam_pkg::OP_LATCH_V;
      mpam_pkg::S_E_FV:     cmd.op = mpam_pkg::OP_LATCH_FV;
      mpam_pkg::S_A_FAIL:   cmd.op = mpam_pkg::OP_WR_FAIL;
      mpam_pkg::S_A_AF:     cmd.op = mpam_pkg::OP_LATCH_AF;
      mpam_pkg::S_A_ACC:    cmd.op = mpam_pkg::OP_WR_ACC;
      mpam_pkg::S_NEXT_C:   cmd.op = mpam_pkg::OP_NEXT_C;
      mpam_pkg::S_DEQ:
        cmd.op = stat.q_empty ? mpam_pkg::OP_B_DONE : mpam_pkg::OP_DEQ_RD;
      mpam_pkg::S_D_U:      cmd.op = mpam_pkg::OP_LD_U;
      mpam_pkg::S_D_FU:     cmd.op = mpam_pkg::OP_LD_FU;
      mpam_pkg::S_FIN:      if (stat.out_free) cmd.op = mpam_pkg::OP_OUT_LOAD;
      default:              cmd.op = mpam_pkg::OP_NONE;
    endcase
  end

endmodule

### src/mpam_dp.sv
// ----------------------------------------------------------------------------
// mpam_dp
// Datapath: trie stores, cursors, build walk registers and result register.
// ----------------------------------------------------------------------------
module mpam_dp #(
  parameter int unsigned MAX_NODES = mpam_pkg::MAX_NODES_DEF,
  parameter int unsigned ALPHABET  = mpam_pkg::ALPHABET_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mpam_pkg::dp_cmd_t               cmd,
  output mpam_pkg::dp_stat_t              stat,
  input  logic                            in_valid,
  input  logic [mpam_pkg::KIND_W-1:0]     kind,
  input  logic [mpam_pkg::LETTER_W-1:0]   letter,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpam_pkg::STATUS_W-1:0]   status,
  output logic                            hit,
  output logic                            found
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = $clog2(ALPHABET);
  localparam int unsigned EDGES = MAX_NODES * ALPHABET;
  localparam int unsigned EW    = $clog2(EDGES);

  function automatic logic [EW-1:0] edge_addr(input logic [NW-1:0] node,
                                              input logic [CW-1:0] ch);
    return EW'(node) * EW'(ALPHABET) + EW'(ch);
  endfunction

  logic [mpam_pkg::KIND_W-1:0]   kind_q;
  logic [mpam_pkg::LETTER_W-1:0] letter_q;
  logic [CW-1:0]                 letter_ch;
  logic                          built, found_flag, is_root;
  logic [NW-1:0]                 ins, scan, u, fu, v, fv;
  logic                          af;
  logic [NW:0]                   nodes_used, head, tail;
  logic [CW-1:0]                 c;
  logic [EW-1:0]                 clr;
  logic [mpam_pkg::STATUS_W-1:0] res_status;
  logic                          res_hit;
  logic                          pool_full, tail_room, clr_node;

  // store ports
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [NW-1:0] e_wdata, e_rdata;
  logic          a_we, a_wdata, a_rdata;
  logic [NW-1:0] a_waddr, a_raddr;
  logic          f_we;
  logic [NW-1:0] f_waddr, f_wdata, f_rdata;
  logic          q_we;
  logic [NW-1:0] q_rdata;

  mpam_ram #(.WIDTH(NW), .DEPTH(EDGES)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));

  mpam_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_acc (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));

  mpam_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(q_rdata), .rdata(f_rdata));

  mpam_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail[NW-1:0]), .wdata(v),
    .raddr(head[NW-1:0]), .rdata(q_rdata));

  assign letter_ch = CW'(letter_q);
  assign pool_full = nodes_used >= (NW+1)'(MAX_NODES);
  assign tail_room = tail < (NW+1)'(MAX_NODES);
  assign clr_node  = clr < EW'(MAX_NODES);

  always_comb begin
    stat.built     = built;
    stat.kind      = kind_q;
    stat.letter_ok = 9'(letter_q) < 9'(ALPHABET);
    stat.edge_zero = e_rdata == '0;
    stat.v_zero    = v == '0;
    stat.is_root   = is_root;
    stat.c_last    = c == CW'(ALPHABET - 1);
    stat.q_empty   = head == tail;
    stat.clr_last  = clr == EW'(EDGES - 1);
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    e_we    = 1'b0;
    e_waddr = edge_addr(u, c);
    e_wdata = e_rdata;
    e_raddr = edge_addr(u, c);
    a_we    = 1'b0;
    a_waddr = v;
    a_wdata = a_rdata | af;
    a_raddr = fv;
    f_we    = 1'b0;
    f_waddr = v;
    f_wdata = fv;
    q_we    = 1'b0;
    unique case (cmd.op)
      mpam_pkg::OP_CLR: begin
        e_we    = 1'b1;
        e_waddr = clr;
        e_wdata = '0;
        a_we    = clr_node;
        a_waddr = NW'(clr);
        a_wdata = 1'b0;
        f_we    = clr_node;
        f_waddr = NW'(clr);
        f_wdata = '0;
      end
      mpam_pkg::OP_RD_INS:  e_raddr = edge_addr(ins, letter_ch);
      mpam_pkg::OP_RD_SCAN: e_raddr = edge_addr(scan, letter_ch);
      mpam_pkg::OP_INS_UPD: begin
        e_we    = stat.edge_zero && !pool_full;
        e_waddr = edge_addr(ins, letter_ch);
        e_wdata = NW'(nodes_used);
      end
      mpam_pkg::OP_MARK: begin
        a_we    = 1'b1;
        a_waddr = ins;
        a_wdata = 1'b1;
      end
      mpam_pkg::OP_TXT_STEP: a_raddr = e_rdata;
      mpam_pkg::OP_B_INIT: begin
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = '0;
      end
      mpam_pkg::OP_LATCH_V: e_raddr = edge_addr(fu, c);
      // missing edge takes the failure target's transition
      mpam_pkg::OP_LATCH_FV: e_we = stat.v_zero;
      mpam_pkg::OP_WR_FAIL:  f_we = 1'b1;
      mpam_pkg::OP_LATCH_AF: a_raddr = v;
      mpam_pkg::OP_WR_ACC: begin
        a_we = 1'b1;
        q_we = tail_room;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      built      <= 1'b0;
      found_flag <= 1'b0;
      ins        <= '0;
      scan       <= '0;
      nodes_used <= (NW+1)'(1);
      clr        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == mpam_pkg::OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        mpam_pkg::OP_CLR: clr <= clr + 1'b1;
        mpam_pkg::OP_TAKE: begin
          if (in_valid) begin
            kind_q     <= kind;
            letter_q   <= letter;
            res_status <= mpam_pkg::ST_OK;
            res_hit    <= 1'b0;
          end
        end
        mpam_pkg::OP_INS_UPD: begin
          if (!stat.edge_zero) begin
            ins <= e_rdata;
          end else if (pool_full) begin
            res_status <= mpam_pkg::ST_POOL_FULL;
          end else begin
            ins        <= NW'(nodes_used);
            nodes_used <= nodes_used + 1'b1;
          end
        end
        mpam_pkg::OP_MARK: ins <= '0;
        mpam_pkg::OP_ERR:  res_status <= mpam_pkg::ST_BAD_PHASE;
        mpam_pkg::OP_ERR_TXT: begin
          res_status <= mpam_pkg::ST_BAD_PHASE;
          scan       <= '0;
        end
        mpam_pkg::OP_TSTART: begin
          scan       <= '0;
          found_flag <= 1'b0;
        end
        mpam_pkg::OP_TXT_STEP: scan <= e_rdata;
        mpam_pkg::OP_TXT_HIT: begin
          res_hit <= a_rdata;
          if (a_rdata) begin
            found_flag <= 1'b1;
          end
        end
        mpam_pkg::OP_B_INIT: begin
          head    <= '0;
          tail    <= '0;
          u       <= '0;
          fu      <= '0;
          c       <= '0;
          is_root <= 1'b1;
        end
        mpam_pkg::OP_LATCH_V: begin
          v  <= e_rdata;
          fv <= '0;  // root children fail to the root
        end
        mpam_pkg::OP_LATCH_FV: fv <= e_rdata;
        mpam_pkg::OP_LATCH_AF: af <= a_rdata;
        mpam_pkg::OP_WR_ACC: begin
          if (tail_room) begin
            tail <= tail + 1'b1;
          end
        end
        mpam_pkg::OP_NEXT_C: c <= c + 1'b1;
        mpam_pkg::OP_DEQ_RD: head <= head + 1'b1;
        mpam_pkg::OP_LD_U:   u <= q_rdata;
        mpam_pkg::OP_LD_FU: begin
          fu      <= f_rdata;
          is_root <= 1'b0;
          c       <= '0;
        end
        mpam_pkg::OP_B_DONE: begin
          built <= 1'b1;
          ins   <= '0;
          scan  <= '0;
        end
        mpam_pkg::OP_OUT_LOAD: begin
          status    <= res_status;
          hit       <= res_hit;
          found     <= found_flag;
        end
        default: ;
      endcase
    end
  end

endmodule

### src/multi_pattern_automaton_matcher_unit.sv
// ----------------------------------------------------------------------------
// multi_pattern_automaton_matcher_unit
// Dictionary matching automaton over a..z: trie build, failure-link walk, scan.
// ----------------------------------------------------------------------------
// One item at a time: the next beat is taken in the cycle after the result loads.
// Build: breadth-first over the nodes; each child gets its failure link and mark and is queued.
// Reset: synchronous; afterwards a clearing pass over the MAX_NODES*ALPHABET edge entries
// zeroes the stores, during which no beat is taken.
module multi_pattern_automaton_matcher_unit #(
  parameter int unsigned MAX_NODES = mpam_pkg::MAX_NODES_DEF,
  parameter int unsigned ALPHABET  = mpam_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpam_pkg::KIND_W-1:0]   kind,
  input  logic [mpam_pkg::LETTER_W-1:0] letter,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpam_pkg::STATUS_W-1:0] status,
  output logic                          hit,
  output logic                          found
);

  // Controller owns sequencing; datapath owns stores and the result register,
  // so an input beat can be taken while the previous result beat waits.
  mpam_pkg::dp_cmd_t  cmd;
  mpam_pkg::dp_stat_t stat;

  mpam_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd));

  mpam_dp #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_valid(in_valid), .kind(kind), .letter(letter),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hit(hit), .found(found));

  // a hit always sets the sticky flag in the same result beat
  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> found)
    else $error("hit without found");

  // a hit only comes from a good text letter
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == mpam_pkg::ST_OK)
    else $error("hit with bad status");

  // clearing pass follows reset; nothing is taken then
  a_clr_block: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing pass");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the multi-pattern automaton matcher. The run
// first sends text items before any build, then grows a dictionary until the
// node pool overflows, then builds the automaton and scans text. Every result
// beat is checked against a behavioural copy of the trie, failure links and scan state.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_NODES   = mpam_pkg::MAX_NODES_DEF;
  localparam int N_LETTERS = mpam_pkg::ALPHABET_DEF;

  typedef struct packed {
    logic [mpam_pkg::STATUS_W-1:0] status;
    logic                          hit;
    logic                          found;
  } match_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [mpam_pkg::KIND_W-1:0]   kind = mpam_pkg::KIND_PAT_LETTER;
  logic [mpam_pkg::LETTER_W-1:0] letter = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mpam_pkg::STATUS_W-1:0] status;
  logic                          hit;
  logic                          found;

  multi_pattern_automaton_matcher_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .letter(letter),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hit(hit), .found(found)
  );

  always #5 clk = ~clk;

  // ---- behavioural copy of the matcher state ----
  int trie_edge [N_NODES*N_LETTERS];
  int accepting [N_NODES];
  int fail_to   [N_NODES];
  int walk_q    [N_NODES];
  int nodes_used  = 1;
  int ins_node    = 0;
  int scan_node   = 0;
  bit built       = 1'b0;
  bit found_state = 1'b0;

  match_result_t pending_results[$];

  int err_count      = 0;
  int beats_sent     = 0;
  int beats_checked  = 0;
  int hits_seen      = 0;
  int pool_full_seen = 0;
  int burst_left     = 0;
  int cyc            = 0;

  // breadth-first walk: failure links, inherited marks, missing edges filled
  function automatic void build_walk();
    int head, tail, u, fu, v, fv, c;
    head = 0;
    tail = 0;
    fail_to[0] = 0;
    for (c = 0; c < N_LETTERS; c++) begin
      v = trie_edge[c];
      if (v != 0 && tail < N_NODES) begin
        fail_to[v] = 0;
        accepting[v] |= accepting[0];
        walk_q[tail++] = v;
      end
    end
    while (head < tail) begin
      u = walk_q[head++];
      fu = fail_to[u];
      for (c = 0; c < N_LETTERS; c++) begin
        v = trie_edge[u*N_LETTERS + c];
        if (v != 0) begin
          fv = trie_edge[fu*N_LETTERS + c];
          fail_to[v] = fv;
          accepting[v] |= accepting[fv];
          if (tail < N_NODES) walk_q[tail++] = v;
        end else begin
          trie_edge[u*N_LETTERS + c] = trie_edge[fu*N_LETTERS + c];
        end
      end
    end
  endfunction

  function automatic match_result_t step_matcher(input logic [mpam_pkg::KIND_W-1:0] k,
                                                 input logic [mpam_pkg::LETTER_W-1:0] l);
    match_result_t r;
    int e, child;
    r = '0;
    r.status = mpam_pkg::ST_OK;
    case (k)
      mpam_pkg::KIND_PAT_LETTER: begin
        if (built || l >= N_LETTERS) begin
          r.status = mpam_pkg::ST_BAD_PHASE;
        end else begin
          e = ins_node*N_LETTERS + l;
          child = trie_edge[e];
          if (child == 0) begin
            if (nodes_used >= N_NODES) begin
              r.status = mpam_pkg::ST_POOL_FULL;
              pool_full_seen++;
            end else begin
              child = nodes_used++;
              trie_edge[e] = child;
              ins_node = child;
            end
          end else begin
            ins_node = child;
          end
        end
      end
      mpam_pkg::KIND_PAT_END: begin
        if (built) r.status = mpam_pkg::ST_BAD_PHASE;
        else begin
          accepting[ins_node] = 1;
          ins_node = 0;
        end
      end
      mpam_pkg::KIND_BUILD: begin
        if (built) r.status = mpam_pkg::ST_BAD_PHASE;
        else begin
          build_walk();
          ins_node = 0;
          scan_node = 0;
          built = 1'b1;
        end
      end
      mpam_pkg::KIND_TEXT_LETTER: begin
        if (!built) r.status = mpam_pkg::ST_BAD_PHASE;
        else if (l >= N_LETTERS) begin
          r.status = mpam_pkg::ST_BAD_PHASE;
          scan_node = 0;
        end else begin
          scan_node = trie_edge[scan_node*N_LETTERS + l];
          r.hit = accepting[scan_node] != 0;
          if (r.hit) found_state = 1'b1;
        end
      end
      mpam_pkg::KIND_TEXT_START: begin
        if (!built) r.status = mpam_pkg::ST_BAD_PHASE;
        else begin
          scan_node = 0;
          found_state = 1'b0;
        end
      end
      default: r.status = mpam_pkg::ST_BAD_PHASE;
    endcase
    r.found = found_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d (beat %0d)", what, got, want, beats_checked);
    err_count++;
  endtask

  // one input beat; the sender may idle between bursts of random length
  task automatic send_item(input logic [mpam_pkg::KIND_W-1:0] k,
                           input logic [mpam_pkg::LETTER_W-1:0] l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= k;
    letter   <= l;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, step_matcher(k, l)};
    beats_sent++;
  endtask

  // hold off the sender until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [mpam_pkg::LETTER_W-1:0] pick_letter(input int span);
    if ($urandom_range(0, 19) == 0)
      return mpam_pkg::LETTER_W'($urandom_range(N_LETTERS, 31));
    return mpam_pkg::LETTER_W'($urandom_range(0, span - 1));
  endfunction

  // ---- receiver: stall pattern plus result check ----
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[10:9])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= $urandom_range(0, 3) != 0;
      2'd2:    out_ready <= cyc[3:1] != 3'd5;
      default: out_ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    match_result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (want.hit) hits_seen++;
      end
    end
  end

  // ---- tests ----
  task automatic test_scan_before_build();
    send_item(mpam_pkg::KIND_TEXT_LETTER, 5'd0);
    send_item(mpam_pkg::KIND_TEXT_START, 5'd0);
    send_item(mpam_pkg::KIND_TEXT_LETTER, 5'd31);
    send_item(3'd5, 5'd0);
    send_item(3'd6, 5'd31);
    send_item(3'd7, 5'd25);
  endtask

  // classic he/she/his dictionary, plus a..z extremes and bad letters
  task automatic test_directed_dictionary();
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd7);  send_item(mpam_pkg::KIND_PAT_LETTER, 5'd4);
    send_item(mpam_pkg::KIND_PAT_END, 5'd0);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd18); send_item(mpam_pkg::KIND_PAT_LETTER, 5'd7);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd4);  send_item(mpam_pkg::KIND_PAT_END, 5'd0);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd7);  send_item(mpam_pkg::KIND_PAT_LETTER, 5'd8);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd26); send_item(mpam_pkg::KIND_PAT_LETTER, 5'd31);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd18); send_item(mpam_pkg::KIND_PAT_END, 5'd0);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd0);  send_item(mpam_pkg::KIND_PAT_LETTER, 5'd25);
    send_item(mpam_pkg::KIND_PAT_END, 5'd0);
  endtask

  // random patterns until the node pool overflows several times
  task automatic test_fill_pool();
    int len, span, n;
    logic [mpam_pkg::KIND_W-1:0] k;
    n = 0;
    while ((pool_full_seen < 8 || n < 40) && n < 3000) begin
      if ($urandom_range(0, 9) == 0) begin
        // any kind except build, which must wait for the full dictionary
        k = mpam_pkg::KIND_W'($urandom_range(0, 6));
        if (k >= mpam_pkg::KIND_BUILD) k = k + 1'b1;
        send_item(k, mpam_pkg::LETTER_W'($urandom));
        n++;
      end else begin
        span = ($urandom_range(0, 9) < 4) ? 4 : N_LETTERS;
        len = (span == 4) ? $urandom_range(1, 4) : $urandom_range(3, 8);
        repeat (len) begin
          send_item(mpam_pkg::KIND_PAT_LETTER, pick_letter(span));
          n++;
        end
        send_item(mpam_pkg::KIND_PAT_END, 5'd0);
        n++;
      end
    end
    // unfinished pattern left hanging into the build
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd1);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd2);
    wait_drained();
  endtask

  task automatic test_build_and_phase();
    send_item(mpam_pkg::KIND_BUILD, 5'd0);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd3);
    send_item(mpam_pkg::KIND_PAT_LETTER, 5'd31);
    send_item(mpam_pkg::KIND_PAT_END, 5'd0);
    send_item(mpam_pkg::KIND_BUILD, 5'd0);
  endtask

  task automatic test_directed_scan();
    int word [6] = '{20, 18, 7, 4, 17, 18};
    send_item(mpam_pkg::KIND_TEXT_START, 5'd0);
    foreach (word[i]) send_item(mpam_pkg::KIND_TEXT_LETTER, mpam_pkg::LETTER_W'(word[i]));
    send_item(mpam_pkg::KIND_TEXT_LETTER, 5'd31);
    send_item(mpam_pkg::KIND_TEXT_LETTER, 5'd0);
    send_item(mpam_pkg::KIND_TEXT_LETTER, 5'd25);
    send_item(mpam_pkg::KIND_TEXT_START, 5'd0);
  endtask

  task automatic test_random_scan();
    int r;
    repeat (230) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        send_item(mpam_pkg::KIND_TEXT_START, mpam_pkg::LETTER_W'($urandom));
      else if (r < 9)
        send_item(mpam_pkg::KIND_W'($urandom_range(0, 7)), mpam_pkg::LETTER_W'($urandom));
      else
        send_item(mpam_pkg::KIND_TEXT_LETTER, pick_letter(r < 70 ? 4 : N_LETTERS));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_scan_before_build();
    test_directed_dictionary();
    test_fill_pool();
    test_build_and_phase();
    test_directed_scan();
    test_random_scan();
    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", pending_results.size(), 0);
    $display("covered %0d beats over %0d trie nodes, %0d pool overflows, %0d hits",
             beats_sent, nodes_used, pool_full_seen, hits_seen);
    $display("checked %0d result beats, %0d mismatches", beats_checked, err_count);
    if (err_count == 0) begin
      $display("multi_pattern_automaton_matcher_unit regression: pass");
    end else begin
      $display("multi_pattern_automaton_matcher_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("multi_pattern_automaton_matcher_unit regression: fail");
    $finish;
  end

endmodule

### files.f
src/mpam_pkg.sv
src/mpam_ram.sv
src/mpam_ctrl.sv
src/mpam_dp.sv
src/multi_pattern_automaton_matcher_unit.sv
tb/sv/tb.sv
